[design/opd_pkg.sv]
// ----------------------------------------------------------------------------
// opd_pkg
// Types, constants and CRC helper shared by the obstacle packet deframer.
// ----------------------------------------------------------------------------
package opd_pkg;

  localparam int unsigned PayLen  = 44;
  localparam int unsigned CrcLen  = 40;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned AddrW   = 3;

  localparam logic [31:0] HdrWord        = 32'h9019_0838;
  localparam logic [31:0] CrcPoly        = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit        = 32'hFFFF_FFFF;
  localparam logic [30:0] LimitResetBits = 31'h40C0_0000;

  typedef enum logic [2:0] {
    StAccepted  = 3'd0,
    StDuplicate = 3'd1,
    StInvalid   = 3'd2,
    StCrcError  = 3'd3,
    StShortRead = 3'd4
  } status_e;

  typedef enum logic {
    OpByte    = 1'b0,
    OpTimeout = 1'b1
  } op_e;

  typedef enum logic {
    RegClearanceLimit = 1'b0
  } reg_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } opd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] timestamp;
    logic [15:0] sequence_res;
    logic        gate_ok;
    logic [31:0] clearance_0;
    logic [31:0] clearance_1;
    logic [31:0] clearance_2;
    logic [31:0] clearance_3;
    logic [31:0] confidence_0;
    logic [31:0] confidence_1;
    logic [31:0] confidence_2;
    logic [31:0] confidence_3;
  } opd_out_t;

  typedef logic [PayLen-1:0][7:0] record_t;

  // one reflected crc-32 byte update
  function automatic logic [31:0] crc_byte(logic [31:0] acc, logic [7:0] b);
    logic [31:0] a;
    a = acc ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      a = a[0] ? ((a >> 1) ^ CrcPoly) : (a >> 1);
    end
    return a;
  endfunction

  function automatic logic [31:0] le32(record_t r, int unsigned at);
    return r[at+3 -: 4];
  endfunction

  localparam logic [31:0] HdrCrc = crc_byte(crc_byte(crc_byte(crc_byte(CrcInit,
                                   HdrWord[31:24]), HdrWord[23:16]), HdrWord[15:8]),
                                   HdrWord[7:0]);

endpackage

[design/opd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// opd_cfg_regs
// APB register file holding the clearance limit.
// ----------------------------------------------------------------------------
module opd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [opd_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [opd_pkg::LimitW-1:0]  limit_o
);
  import opd_pkg::*;

  logic [LimitW-1:0] limit_q;
  logic              wr_en;
  reg_e              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[AddrW-1]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitResetBits;
    end else if (wr_en && reg_sel == RegClearanceLimit) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegClearanceLimit: prdata = {1'b0, limit_q};
      default:           prdata = '0;
    endcase
  end

  assign limit_o = limit_q;

endmodule

[design/opd_pkt_check.sv]
// ----------------------------------------------------------------------------
// opd_pkt_check
// Checks a complete record: crc, field validity, duplicate sequence.
// ----------------------------------------------------------------------------
module opd_pkt_check (
  input  opd_pkg::record_t             rec_i,
  input  logic [31:0]                  crc_i,
  input  logic [opd_pkg::LimitW-1:0]   limit_i,
  input  logic [15:0]                  last_seq_i,
  output opd_pkg::opd_out_t            res_o,
  output logic                         take_seq_o
);
  import opd_pkg::*;

  logic [31:0] clr [4];
  logic [31:0] cnf [4];
  logic [15:0] seq;
  logic [7:0]  gate;
  logic        crc_ok;
  logic        bad;
  status_e     status;

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      clr[d] = le32(rec_i, 8 + 4 * d);
      cnf[d] = le32(rec_i, 24 + 4 * d);
    end
    seq    = {rec_i[5], rec_i[4]};
    gate   = rec_i[6];
    crc_ok = (~crc_i) == le32(rec_i, CrcLen);
    bad    = (seq == '0) || (gate > 8'd1);
    for (int d = 0; d < 4; d++) begin
      if (clr[d][30:23] == 8'hFF || cnf[d][30:23] == 8'hFF) bad = 1'b1;
      if (clr[d][31] && clr[d][30:0] != '0) bad = 1'b1;
      if (!clr[d][31] && clr[d][30:0] > limit_i) bad = 1'b1;
    end
    priority if (!crc_ok)        status = StCrcError;
    else if (bad)                status = StInvalid;
    else if (seq == last_seq_i)  status = StDuplicate;
    else                         status = StAccepted;
  end

  assign take_seq_o = (status == StAccepted);

  always_comb begin
    res_o              = '0;
    res_o.status       = status;
    res_o.timestamp    = le32(rec_i, 0);
    res_o.sequence_res = seq;
    res_o.gate_ok      = (status == StAccepted) ? gate[0] : 1'b0;
    res_o.clearance_0  = clr[0];
    res_o.clearance_1  = clr[1];
    res_o.clearance_2  = clr[2];
    res_o.clearance_3  = clr[3];
    res_o.confidence_0 = cnf[0];
    res_o.confidence_1 = cnf[1];
    res_o.confidence_2 = cnf[2];
    res_o.confidence_3 = cnf[3];
  end

endmodule

[design/obstacle_packet_deframer.sv]
// ----------------------------------------------------------------------------
// obstacle_packet_deframer
// Hunts for the 90 19 08 38 header, collects a 44-byte record, checks crc
// and fields, and reports one status beat per packet or payload timeout.
//
//   channel | dir | handshake              | beat
//   in      | in  | in_valid_i / in_stall_o | opd_in_t (operation, rx_byte)
//   out     | out | out_valid_o/out_stall_i | opd_out_t (status + packet)
//   cfg     | in  | apb psel/penable       | clearance_limit_bits at 0x0
//
// one beat per cycle unless an output stall holds the input; a beat is held in the
// input register and its result is registered in the output register
// reset returns to hunting with an empty window and limit 6.0
// an output stall holds the result and stalls input once the input register
// is also full
// ----------------------------------------------------------------------------
module obstacle_packet_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  opd_pkg::opd_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output opd_pkg::opd_out_t          out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [opd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import opd_pkg::*;

  logic              in_valid_q;
  opd_in_t           in_q;
  logic              out_valid_q;
  opd_out_t          out_q, out_d;
  logic [31:0]       win_q, win_d;
  logic              in_pkt_q, in_pkt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [31:0]       crc_q, crc_d;
  record_t           pay_q, pay_d;
  logic [15:0]       last_seq_q;
  logic [LimitW-1:0] limit;
  logic              out_free, fire, accept, has_res, take_seq, chk_take;
  opd_out_t          chk_res;

  opd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  assign pay_d = {in_q.rx_byte, pay_q[PayLen-1:1]};

  opd_pkt_check u_check (
    .rec_i      (pay_d),
    .crc_i      (crc_q),
    .limit_i    (limit),
    .last_seq_i (last_seq_q),
    .res_o      (chk_res),
    .take_seq_o (chk_take)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    win_d    = win_q;
    in_pkt_d = in_pkt_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    has_res  = 1'b0;
    take_seq = 1'b0;
    out_d    = chk_res;
    if (!in_pkt_q) begin
      if (op_e'(in_q.operation) == OpByte) begin
        win_d = {win_q[23:0], in_q.rx_byte};
        if (win_d == HdrWord) begin
          in_pkt_d = 1'b1;
          idx_d    = '0;
          crc_d    = HdrCrc;
        end
      end
    end else if (op_e'(in_q.operation) == OpTimeout) begin
      has_res      = 1'b1;
      out_d        = '0;
      out_d.status = StShortRead;
      win_d        = '0;
      in_pkt_d     = 1'b0;
      idx_d        = '0;
      crc_d        = CrcInit;
    end else begin
      if (idx_q < IdxW'(CrcLen)) crc_d = crc_byte(crc_q, in_q.rx_byte);
      idx_d = idx_q + 1'b1;
      if (idx_q == IdxW'(PayLen - 1)) begin
        has_res  = 1'b1;
        take_seq = chk_take;
        win_d    = '0;
        in_pkt_d = 1'b0;
        idx_d    = '0;
        crc_d    = CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
      in_pkt_q    <= 1'b0;
      idx_q       <= '0;
      crc_q       <= CrcInit;
      last_seq_q  <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= fire && has_res;
      end
      if (fire) begin
        win_q    <= win_d;
        in_pkt_q <= in_pkt_d;
        idx_q    <= idx_d;
        crc_q    <= crc_d;
        if (take_seq) last_seq_q <= chk_res.sequence_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (fire && in_pkt_q && op_e'(in_q.operation) == OpByte) pay_q <= pay_d;
    if (fire && has_res) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  a_hunt_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_pkt_q |-> (idx_q == '0))
    else $error("byte index nonzero while hunting");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < IdxW'(PayLen))
    else $error("byte index beyond record");

  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && has_res) |=> out_valid_q)
    else $error("result lost");

  a_seq_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_seq_q) |-> (last_seq_q != '0))
    else $error("zero sequence accepted");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the obstacle packet deframer. Byte and timeout beats
// go in through the input channel: framed packets with random fields, broken
// and cut packets, and line noise. A built-in deframer predicts the status
// beat of every packet, and the output monitor checks each field in order.
// The input idles and the output stalls at random. The clearance limit is rewritten
// over the APB port between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import opd_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned PhasePkts  = 2;
  localparam int unsigned MaxShown   = 10;
  localparam logic [AddrW-1:0] LimitAddr = AddrW'(4 * RegClearanceLimit);
  localparam logic [AddrW-1:0] SpareAddr = LimitAddr + AddrW'(4);
  localparam logic [30:0] LimitMax = 31'h7F7F_FFFF;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  opd_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  opd_out_t         out_data;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [31:0]      pwdata  = '0;
  logic [31:0]      prdata;
  logic             pready;

  // deframer state as the bench sees it
  logic [31:0] hunt_win   = '0;
  logic        in_pkt     = 1'b0;
  int unsigned rec_idx    = 0;
  logic [31:0] crc_run    = CrcInit;
  logic [7:0]  rec [PayLen];
  logic [15:0] last_seq   = '0;
  logic [30:0] limit_bits = LimitResetBits;

  opd_out_t    exp_q[$];
  opd_in_t     pend_q[$];
  int unsigned n_err      = 0;
  int unsigned n_cycles   = 0;
  int unsigned gen_items  = 0;
  int unsigned gen_pkts   = 0;
  logic [15:0] prev_seq   = '0;
  int unsigned gap_left   = 0;
  int unsigned calm_left  = 0;
  int unsigned stall_run  = 0;
  logic        stall_next = 1'b0;

  obstacle_packet_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] crc32_feed(logic [31:0] c, logic [7:0] d);
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ ((c[0] ^ d[k]) ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

  function automatic logic [31:0] header_crc();
    logic [31:0] c;
    c = CrcInit;
    for (int s = 3; s >= 0; s--) c = crc32_feed(c, HdrWord[8*s +: 8]);
    return c;
  endfunction

  function automatic logic [31:0] rec_word(int unsigned at);
    return {rec[at+3], rec[at+2], rec[at+1], rec[at]};
  endfunction

  function automatic void rehunt();
    hunt_win = '0;
    in_pkt   = 1'b0;
    rec_idx  = 0;
    crc_run  = CrcInit;
  endfunction

  function automatic void predict_beat(opd_in_t b);
    opd_out_t    r;
    logic [15:0] seq;
    logic [7:0]  gate;
    logic [31:0] c, f;
    logic        bad;
    if (!in_pkt) begin
      if (b.operation == OpByte) begin
        hunt_win = {hunt_win[23:0], b.rx_byte};
        if (hunt_win == HdrWord) begin
          in_pkt  = 1'b1;
          rec_idx = 0;
          crc_run = header_crc();
        end
      end
      return;
    end
    r = '0;
    if (b.operation == OpTimeout) begin
      r.status = StShortRead;
      exp_q.push_back(r);
      rehunt();
      return;
    end
    rec[rec_idx] = b.rx_byte;
    if (rec_idx < CrcLen) crc_run = crc32_feed(crc_run, b.rx_byte);
    rec_idx++;
    if (rec_idx < PayLen) return;
    seq  = {rec[5], rec[4]};
    gate = rec[6];
    if (~crc_run != rec_word(CrcLen)) begin
      r.status = StCrcError;
    end else begin
      bad = (seq == 16'd0) || (gate > 8'd1);
      for (int d = 0; d < 4; d++) begin
        c = rec_word(8 + 4*d);
        f = rec_word(24 + 4*d);
        if (c[30:23] == 8'hFF || f[30:23] == 8'hFF) bad = 1'b1;
        else if (c[31] && c[30:0] != '0) bad = 1'b1;
        else if (!c[31] && c[30:0] > limit_bits) bad = 1'b1;
      end
      if (bad) begin
        r.status = StInvalid;
      end else if (seq == last_seq) begin
        r.status = StDuplicate;
      end else begin
        r.status = StAccepted;
        last_seq = seq;
      end
    end
    r.timestamp    = rec_word(0);
    r.sequence_res = seq;
    r.gate_ok      = (r.status == StAccepted) ? gate[0] : 1'b0;
    r.clearance_0  = rec_word(8);
    r.clearance_1  = rec_word(12);
    r.clearance_2  = rec_word(16);
    r.clearance_3  = rec_word(20);
    r.confidence_0 = rec_word(24);
    r.confidence_1 = rec_word(28);
    r.confidence_2 = rec_word(32);
    r.confidence_3 = rec_word(36);
    exp_q.push_back(r);
    rehunt();
  endfunction

  function automatic void flag_error(string msg);
    n_err++;
    if (n_err <= MaxShown) $display("%s", msg);
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_data  <= pend_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) predict_beat(in_data);
  end

  always @(posedge clk_i) begin
    opd_out_t    e;
    logic [11:0] diff;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_q.size() == 0) begin
          flag_error($sformatf("result with nothing expected: %h", out_data));
        end else begin
          e = exp_q.pop_front();
          diff = {e.status !== out_data.status, e.timestamp !== out_data.timestamp,
                  e.sequence_res !== out_data.sequence_res,
                  e.gate_ok !== out_data.gate_ok,
                  e.clearance_0 !== out_data.clearance_0,
                  e.clearance_1 !== out_data.clearance_1,
                  e.clearance_2 !== out_data.clearance_2,
                  e.clearance_3 !== out_data.clearance_3,
                  e.confidence_0 !== out_data.confidence_0,
                  e.confidence_1 !== out_data.confidence_1,
                  e.confidence_2 !== out_data.confidence_2,
                  e.confidence_3 !== out_data.confidence_3};
          if (diff != '0) begin
            flag_error($sformatf("result mismatch, fields %b\n  expected %h\n  actual   %h",
                                 diff, e, out_data));
          end
        end
      end
      if (stall_run == 0) begin
        stall_next = ($urandom_range(0, 9) < 4);
        if (stall_next) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: stall_run = $urandom_range(1, 3);
            19:      stall_run = $urandom_range(20, 60);
            default: stall_run = $urandom_range(4, 12);
          endcase
        end else begin
          stall_run = ($urandom_range(0, 19) < 12) ? $urandom_range(1, 6)
                                                   : $urandom_range(10, 150);
        end
      end
      stall_run--;
      out_stall <= stall_next;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic apb_write(logic [AddrW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LimitAddr) limit_bits = data[30:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (pend_q.size() != 0 || in_valid || exp_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_byte(logic [7:0] v);
    pend_q.push_back(opd_in_t'{operation: OpByte, rx_byte: v});
    gen_items++;
  endtask

  task automatic push_timeout();
    pend_q.push_back(opd_in_t'{operation: OpTimeout, rx_byte: 8'($urandom)});
    gen_items++;
  endtask

  // header from byte hdr_from on, then cut_at payload bytes, timeout if cut short
  task automatic queue_packet(logic [31:0] ts, logic [15:0] seq, logic [7:0] gate,
                              logic [3:0][31:0] clr, logic [3:0][31:0] conf,
                              logic [31:0] crc_flip, int hdr_from, int cut_at);
    logic [7:0]  pl [PayLen];
    logic [31:0] crc;
    for (int k = 0; k < 4; k++) pl[k] = ts[8*k +: 8];
    pl[4] = seq[7:0];
    pl[5] = seq[15:8];
    pl[6] = gate;
    pl[7] = 8'($urandom);
    for (int d = 0; d < 4; d++) begin
      for (int k = 0; k < 4; k++) begin
        pl[8 + 4*d + k]  = clr[d][8*k +: 8];
        pl[24 + 4*d + k] = conf[d][8*k +: 8];
      end
    end
    crc = header_crc();
    for (int k = 0; k < CrcLen; k++) crc = crc32_feed(crc, pl[k]);
    crc = ~crc ^ crc_flip;
    for (int k = 0; k < 4; k++) pl[CrcLen + k] = crc[8*k +: 8];
    for (int s = hdr_from; s < 4; s++) push_byte(HdrWord[31 - 8*s -: 8]);
    for (int k = 0; k < cut_at; k++) push_byte(pl[k]);
    if (cut_at < PayLen) push_timeout();
    gen_pkts++;
  endtask

  function automatic logic [31:0] good_clearance(logic [30:0] lim);
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return {1'b0, lim};
      2:       return 32'h0;
      default: return {1'b0, 31'($urandom_range(0, 32'(lim)))};
    endcase
  endfunction

  task automatic queue_random_packet(logic [30:0] lim, int hdr_from, int cut_at);
    logic [3:0][31:0] clr, conf;
    logic [31:0]      ts, flip;
    logic [15:0]      seq;
    logic [7:0]       gate;
    int unsigned      d;
    ts = $urandom;
    if ($urandom_range(0, 19) == 0) ts = '1;
    else if ($urandom_range(0, 19) == 0) ts = '0;
    case ($urandom_range(0, 19))
      0, 1:          seq = '0;
      2, 3, 4, 5, 6: seq = prev_seq;
      7:             seq = '1;
      8:             seq = 16'd1;
      default:       seq = 16'($urandom);
    endcase
    prev_seq = seq;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8:           gate = 8'd0;
      9, 10, 11, 12, 13, 14, 15, 16, 17: gate = 8'd1;
      default:                             gate = 8'($urandom_range(2, 255));
    endcase
    for (int k = 0; k < 4; k++) begin
      clr[k]  = good_clearance(lim);
      conf[k] = $urandom;
      if (conf[k][30:23] == 8'hFF) conf[k][30:23] = 8'h7F;
    end
    if ($urandom_range(0, 3) == 0) begin
      d = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0: clr[d] = {1'b0, 31'($urandom_range(32'(lim) + 1, 32'h7FFF_FFFF))};
        1: clr[d] = {1'b1, 31'($urandom_range(1, 32'h7FFF_FFFF))};
        2: clr[d][30:23] = 8'hFF;
        default: conf[d][30:23] = 8'hFF;
      endcase
    end
    flip = ($urandom_range(0, 9) == 0) ? (32'h1 << $urandom_range(0, 31)) : 32'h0;
    queue_packet(ts, seq, gate, clr, conf, flip, hdr_from, cut_at);
  endtask

  task automatic run_phase(logic [30:0] lim);
    int unsigned items0, pkts0, k, n;
    logic [7:0]  junk;
    apb_write(LimitAddr, {1'($urandom), lim});
    items0 = gen_items;
    pkts0  = gen_pkts;
    while (gen_items - items0 < PhaseItems || gen_pkts - pkts0 < PhasePkts) begin
      case ($urandom_range(0, 19))
        13, 14: queue_random_packet(lim, 0, $urandom_range(0, PayLen - 1));
        15: begin
          push_byte(HdrWord[31:24]);
          queue_random_packet(lim, 0, PayLen);
        end
        16, 17: begin
          // line noise with stray header bytes and timeouts
          n = $urandom_range(1, 10);
          repeat (n) begin
            k = $urandom_range(0, 9);
            if (k < 2) push_timeout();
            else if (k < 4) push_byte(HdrWord[8*$urandom_range(0, 3) +: 8]);
            else push_byte(8'($urandom));
          end
        end
        18, 19: begin
          // header split by a timeout, or broken off by a wrong byte
          k = $urandom_range(1, 3);
          for (int s = 0; s < k; s++) push_byte(HdrWord[31 - 8*s -: 8]);
          if ($urandom_range(0, 1) == 0) begin
            push_timeout();
            queue_random_packet(lim, k, PayLen);
          end else begin
            junk = 8'($urandom);
            if (junk == HdrWord[31 - 8*k -: 8]) junk = ~junk;
            push_byte(junk);
          end
        end
        default: queue_random_packet(lim, 0, PayLen);
      endcase
    end
    wait_idle();
  endtask

  initial begin
    logic [3:0][31:0] ok_clr, ok_conf, clr, conf;
    ok_clr  = {32'h40C0_0000, 32'h8000_0000, 32'h0000_0000, 32'h3F80_0000};
    ok_conf = {32'h3F80_0000, 32'h0000_0000, 32'hFF7F_FFFF, 32'h7F7F_FFFF};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_write(SpareAddr, $urandom);
    apb_write(LimitAddr, {1'b0, LimitResetBits});

    push_timeout();
    push_byte(HdrWord[31:24]);
    push_byte(HdrWord[23:16]);
    push_timeout();
    queue_packet('1, 16'd1, 8'd1, ok_clr, ok_conf, '0, 2, PayLen);
    queue_packet('0, 16'd1, 8'd0, ok_clr, ok_conf, '0, 0, PayLen);
    queue_packet('0, '1, 8'd0, '0, '0, '0, 0, PayLen);
    queue_packet(32'h1234_5678, 16'd0, 8'd1, ok_clr, ok_conf, '0, 0, PayLen);
    queue_packet(32'h1234_5678, 16'd2, 8'hFF, ok_clr, ok_conf, '0, 0, PayLen);
    clr = ok_clr;
    clr[2] = 32'h40C0_0001;
    queue_packet(32'h1, 16'd3, 8'd0, clr, ok_conf, '0, 0, PayLen);
    clr = ok_clr;
    clr[1] = 32'h8000_0001;
    queue_packet(32'h2, 16'd4, 8'd0, clr, ok_conf, '0, 0, PayLen);
    clr = ok_clr;
    clr[0] = 32'hFFC0_0000;
    queue_packet(32'h3, 16'd5, 8'd0, clr, ok_conf, '0, 0, PayLen);
    conf = ok_conf;
    conf[3] = 32'h7FC0_0000;
    queue_packet(32'h4, 16'd6, 8'd0, ok_clr, conf, '0, 0, PayLen);
    conf = ok_conf;
    conf[0] = 32'hFF80_0000;
    queue_packet(32'h5, 16'd6, 8'd0, ok_clr, conf, '0, 0, PayLen);
    queue_packet(32'h6, 16'd7, 8'd1, ok_clr, ok_conf, 32'h8000_0000, 0, PayLen);
    queue_packet(32'h7, 16'd8, 8'd1, ok_clr, ok_conf, '0, 0, 0);
    queue_packet(32'h8, 16'd9, 8'd1, ok_clr, ok_conf, '0, 0, PayLen - 1);
    push_byte(HdrWord[31:24]);
    queue_packet(32'hFFFF_0000, 16'h1234, 8'd1, ok_clr, ok_conf, '0, 0, PayLen);
    wait_idle();

    run_phase(LimitMax);
    run_phase(31'h0);
    run_phase(31'($urandom_range(32'h3F80_0000, 32'h4200_0000)));
    run_phase(LimitResetBits);
    run_phase(31'($urandom_range(0, 32'(LimitMax))));

    if (n_err == 0 && exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
design/opd_pkg.sv
design/opd_cfg_regs.sv
design/opd_pkt_check.sv
design/obstacle_packet_deframer.sv
tb/tb_top.sv
